[rtl/mpbt_pkg.sv]
// Shared types, codes and a helper function for the peer ban table.
package mpbt_pkg;

   localparam int AddrWidth  = 64;
   localparam int ScoreWidth = 32;
   localparam int TimeWidth  = 48;

   localparam logic [TimeWidth-1:0]  TimeMax  = {TimeWidth{1'b1}};
   localparam logic [ScoreWidth-1:0] ScoreMax = {ScoreWidth{1'b1}};

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_LOOKUP = 2'd1,
      KIND_REMOVE = 2'd2,
      KIND_OTHER  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CSR_SCORE_LIMIT = 2'd0,
      CSR_BAN_TICKS   = 2'd1,
      CSR_TABLE_LIMIT = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [AddrWidth-1:0]  addr_high;
      logic [AddrWidth-1:0]  addr_low;
      logic [ScoreWidth-1:0] score;
      logic [TimeWidth-1:0]  ban_end;
   } entry_type;

   // Saturating add of a 32-bit duration to a 48-bit time.
   function automatic logic [TimeWidth-1:0] time_add(input logic [TimeWidth-1:0] now_t,
                                                     input logic [31:0] dur);
      logic [TimeWidth:0] sum;
      sum = {1'b0, now_t} + {{(TimeWidth-31){1'b0}}, dur};
      if (sum[TimeWidth]) begin
         time_add = TimeMax;
      end else begin
         time_add = sum[TimeWidth-1:0];
      end
   endfunction

endpackage

[rtl/mpbt_entry_ram.sv]
// Entry memory with one write port and one read port; read data is registered.
module mpbt_entry_ram
   import mpbt_pkg::*;
#(
   parameter int Depth = 256,
   parameter int IdxWidth = 8
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IdxWidth-1:0] wr_idx,
   input  entry_type           wr_data,
   input  logic [IdxWidth-1:0] rd_idx,
   output entry_type           rd_data
);

   entry_type mem [Depth];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/misbehaving_peer_ban_table_top.sv]
// Top level of the misbehaving-peer ban table: sequencer, scan unit and outputs.
//
//   Channel  Direction  Handshake              Word carried
//   req_     in         req_valid/req_ready    kind, address_high/low, now
//   rsp_     out        rsp_valid/rsp_ready    found, score_out, banned, ban_end, occupancy
//   csr_     in         csr_valid/csr_ready    csr_index, csr_data
//
// Every word runs one full scan of the table through the single read port of the entry
// memory. The decision state follows, then the write-back state that also loads the
// result; an add that escalates a ban passes through the multiply and sum states ST_MUL
// and ST_BIG before write-back. The next word is accepted in the idle state after that.
// An add of a new address into a full table evicts one entry per extra scan and
// decision, so such a word takes (evictions+1) scans. Reset clears the valid bits and
// the entry count at once; no clearing pass is needed. A finished word waits in the
// write-back state until the output register is free; req_ready is low from acceptance
// until that result register has been loaded.
module misbehaving_peer_ban_table_top
   import mpbt_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [63:0] req_address_high,
   input  logic [63:0] req_address_low,
   input  logic [47:0] req_now,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [31:0] rsp_score_out,
   output logic        rsp_banned,
   output logic [47:0] rsp_ban_end,
   output logic [8:0]  rsp_occupancy,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int LW = (CW > 9) ? CW : 9;
   localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCAN   = 6'b000010,
      ST_DECIDE = 6'b000100,
      ST_MUL    = 6'b001000,
      ST_BIG    = 6'b010000,
      ST_WRITE  = 6'b100000
   } state_type;

   // Configuration registers.
   logic [15:0] score_limit_ff;
   logic [31:0] ban_ticks_ff;
   logic [8:0]  table_limit_ff;

   state_type state_ff, state_in;

   // Latched request word.
   kind_type    kind_ff;
   logic [63:0] hi_ff, lo_ff;
   logic [47:0] now_ff;

   // Table bookkeeping.
   logic [CAPACITY-1:0] valid_ff;
   logic [CW-1:0]       count_ff;

   // Scan unit state.
   logic [CW-1:0] cnt_ff;
   logic          rd_vld_ff;
   logic [IW-1:0] rd_idx_ff;
   logic          hit_ff, free_f_ff, min_f_ff;
   logic [IW-1:0] hit_idx_ff, free_idx_ff, min_idx_ff;
   logic [47:0]   min_end_ff;
   logic [31:0]   hit_score_ff;
   logic [47:0]   hit_end_ff;
   logic [63:0]   prod_ff;

   // Result register.
   logic        rsp_valid_ff;
   logic        rsp_found_ff;
   logic [31:0] rsp_score_ff;
   logic        rsp_banned_ff;
   logic [47:0] rsp_end_ff;
   logic [8:0]  rsp_occ_ff;

   entry_type rd_data;
   entry_type wr_data;
   logic      wr_en;
   logic [IW-1:0] rd_addr;

   assign rd_addr = cnt_ff[IW-1:0];
   assign wr_en   = (state_ff == ST_WRITE) && (kind_ff == KIND_ADD);
   assign wr_data = '{addr_high: hi_ff, addr_low: lo_ff, score: hit_score_ff,
                      ban_end: hit_end_ff};

   mpbt_entry_ram #(
      .Depth(CAPACITY),
      .IdxWidth(IW)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_idx (hit_idx_ff),
      .wr_data(wr_data),
      .rd_idx (rd_addr),
      .rd_data(rd_data)
   );

   // Effective table limit, clamped to the physical capacity.
   logic [LW-1:0] tl_ext, cap_ext, count_ext, lim_ext;
   logic          need_evict;
   assign tl_ext     = LW'(table_limit_ff);
   assign cap_ext    = LW'(CapCount);
   assign count_ext  = LW'(count_ff);
   assign lim_ext    = (tl_ext > cap_ext) ? cap_ext : tl_ext;
   assign need_evict = (count_ext > LW'(1)) && (count_ext >= lim_ext);

   // Saturating increment of the hit entry's score.
   logic [31:0] sc_inc;
   assign sc_inc = (hit_score_ff == ScoreMax) ? hit_score_ff : hit_score_ff + 32'd1;

   // Long-ban end time: now + 2*ban_ticks*score, saturating.
   logic [65:0] big_sum;
   assign big_sum = {1'b0, prod_ff, 1'b0} + {18'd0, now_ff};

   logic scan_last;
   assign scan_last = (cnt_ff == CapCount);

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // The entry is reported after an add, or after any kind but a remove that found it.
   logic show;
   assign show = (kind_ff == KIND_ADD) || ((kind_ff != KIND_REMOVE) && hit_ff);

   logic done_now;   // a result is loaded into the output register this cycle

   always_comb begin
      state_in = state_ff;
      done_now = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            case (kind_ff)
               KIND_ADD: begin
                  if (hit_ff) begin
                     if (sc_inc > {16'd0, score_limit_ff}) begin
                        state_in = ST_MUL;
                     end else begin
                        state_in = ST_WRITE;
                     end
                  end else if (need_evict) begin
                     state_in = ST_SCAN;
                  end else begin
                     state_in = ST_WRITE;
                  end
               end
               default: begin
                  state_in = ST_WRITE;
               end
            endcase
         end
         ST_MUL:   state_in = ST_BIG;
         ST_BIG:   state_in = ST_WRITE;
         ST_WRITE: begin
            if (out_free) begin
               state_in = ST_IDLE;
               done_now = 1'b1;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         valid_ff       <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         score_limit_ff <= 16'd2;
         ban_ticks_ff   <= 32'd3600;
         table_limit_ff <= 9'd256;
         rd_vld_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_SCORE_LIMIT: score_limit_ff <= csr_data[15:0];
               CSR_BAN_TICKS:   ban_ticks_ff   <= csr_data;
               CSR_TABLE_LIMIT: table_limit_ff <= csr_data[8:0];
               default: ;
            endcase
         end

         if (done_now) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         rd_vld_ff <= (state_ff == ST_SCAN) && !scan_last;

         if (state_ff == ST_DECIDE) begin
            if (kind_ff == KIND_ADD) begin
               if (!hit_ff && need_evict) begin
                  valid_ff[min_idx_ff] <= 1'b0;
                  count_ff             <= count_ff - CW'(1);
               end else if (!hit_ff) begin
                  count_ff <= count_ff + CW'(1);
               end
            end else if (kind_ff == KIND_REMOVE && hit_ff) begin
               valid_ff[hit_idx_ff] <= 1'b0;
               count_ff             <= count_ff - CW'(1);
            end
         end
         if (state_ff == ST_WRITE && kind_ff == KIND_ADD) begin
            valid_ff[hit_idx_ff] <= 1'b1;
         end
      end
   end

   // Datapath registers; no reset needed.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         kind_ff   <= kind_type'(req_kind);
         hi_ff     <= req_address_high;
         lo_ff     <= req_address_low;
         now_ff    <= req_now;
      end

      // Scan trackers restart whenever a scan is entered.
      if (state_in == ST_SCAN && state_ff != ST_SCAN) begin
         cnt_ff    <= '0;
         hit_ff    <= 1'b0;
         free_f_ff <= 1'b0;
         min_f_ff  <= 1'b0;
      end else if (state_ff == ST_SCAN) begin
         if (!scan_last) begin
            cnt_ff <= cnt_ff + CW'(1);
         end
         rd_idx_ff <= rd_addr;
         if (rd_vld_ff) begin
            if (valid_ff[rd_idx_ff]) begin
               if (rd_data.addr_high == hi_ff && rd_data.addr_low == lo_ff) begin
                  hit_ff       <= 1'b1;
                  hit_idx_ff   <= rd_idx_ff;
                  hit_score_ff <= rd_data.score;
                  hit_end_ff   <= rd_data.ban_end;
               end
               if (!min_f_ff || rd_data.ban_end < min_end_ff) begin
                  min_f_ff   <= 1'b1;
                  min_idx_ff <= rd_idx_ff;
                  min_end_ff <= rd_data.ban_end;
               end
            end else if (!free_f_ff) begin
               free_f_ff   <= 1'b1;
               free_idx_ff <= rd_idx_ff;
            end
         end
      end

      if (state_ff == ST_DECIDE && kind_ff == KIND_ADD) begin
         if (hit_ff) begin
            hit_score_ff <= sc_inc;
            if (sc_inc == {16'd0, score_limit_ff}) begin
               hit_end_ff <= time_add(now_ff, ban_ticks_ff);
            end
         end else if (!need_evict) begin
            hit_idx_ff   <= free_idx_ff;
            hit_score_ff <= 32'd1;
            hit_end_ff   <= time_add(now_ff, ban_ticks_ff);
         end
      end

      if (state_ff == ST_MUL) begin
         prod_ff <= ban_ticks_ff * hit_score_ff;
      end
      if (state_ff == ST_BIG) begin
         hit_end_ff <= (big_sum > {18'd0, TimeMax}) ? TimeMax : big_sum[47:0];
      end

      if (done_now) begin
         rsp_found_ff  <= hit_ff;
         rsp_score_ff  <= show ? hit_score_ff : 32'd0;
         rsp_end_ff    <= show ? hit_end_ff : 48'd0;
         rsp_banned_ff <= show && (hit_score_ff >= {16'd0, score_limit_ff})
                          && (hit_end_ff > now_ff);
         rsp_occ_ff    <= 9'(count_ff);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_score_out = rsp_score_ff;
   assign rsp_banned    = rsp_banned_ff;
   assign rsp_ban_end   = rsp_end_ff;
   assign rsp_occupancy = rsp_occ_ff;

   // The entry count never exceeds the capacity of the table.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CapCount)
      else $error("entry count above capacity");

   // An accepted word always starts with a table scan.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_SCAN)
      else $error("accepted word did not start a scan");

   // A slot written back by an add is marked valid on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE && kind_ff == KIND_ADD |=> valid_ff[$past(hit_idx_ff)])
      else $error("written slot not valid");

endmodule
